// File: sv/unicode_name_collator_assert.svh
// Assertion macros used by the collator RTL.
`ifndef UNICODE_NAME_COLLATOR_ASSERT_SVH
`define UNICODE_NAME_COLLATOR_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define UCOLL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define UCOLL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/ucoll_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucoll_pkg
// Types, constants and helper functions for the UTF-16 name collator.
// ----------------------------------------------------------------------------
package ucoll_pkg;

    localparam int UPCASE_DEPTH = 65536;
    localparam int TABLE_AW     = $clog2(UPCASE_DEPTH);
    localparam int CODE_W       = 16;
    localparam int LEN_W        = 17;
    localparam int RESULT_W     = 32;

    localparam logic [LEN_W-1:0] DEPTH_LIMIT = LEN_W'(UPCASE_DEPTH);

    // Opcodes carried in tuser.
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_COMPARE = 1'b1;

    // compare_mode values.
    localparam logic MODE_COLLATE = 1'b0;
    localparam logic MODE_EQUAL   = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_COMPARE_MODE  = 2'd0;
    localparam logic [1:0] CFG_IGNORE_CASE   = 2'd1;
    localparam logic [1:0] CFG_UPCASE_LENGTH = 2'd2;
    localparam logic [1:0] CFG_ERROR_VALUE   = 2'd3;

    localparam logic [RESULT_W-1:0] RES_LESS    = '1;
    localparam logic [RESULT_W-1:0] RES_ZERO    = '0;
    localparam logic [RESULT_W-1:0] RES_ONE     = RESULT_W'(1);
    localparam logic [RESULT_W-1:0] ERROR_RESET = RESULT_W'(-2);

    localparam logic [CODE_W-1:0] ASCII_LIMIT = CODE_W'(64);
    localparam logic [CODE_W-1:0] CH_QUOTE    = CODE_W'(8'h22);
    localparam logic [CODE_W-1:0] CH_STAR     = CODE_W'(8'h2A);
    localparam logic [CODE_W-1:0] CH_LESS     = CODE_W'(8'h3C);
    localparam logic [CODE_W-1:0] CH_GREATER  = CODE_W'(8'h3E);
    localparam logic [CODE_W-1:0] CH_QUESTION = CODE_W'(8'h3F);

    // True for the five characters " * < > ? that a file name may not hold.
    function automatic logic illegal_code(input logic [CODE_W-1:0] c);
        logic hit;
        hit = (c == CH_QUOTE) || (c == CH_STAR) || (c == CH_LESS) ||
              (c == CH_GREATER) || (c == CH_QUESTION);
        return (c < ASCII_LIMIT) && hit;
    endfunction

endpackage

// File: sv/ucoll_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucoll_table
// Upcase table memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module ucoll_table (
    input  logic                          clk,
    input  logic                          we,
    input  logic [ucoll_pkg::TABLE_AW-1:0] waddr,
    input  logic [ucoll_pkg::CODE_W-1:0]   wdata,
    input  logic                          re,
    input  logic [ucoll_pkg::TABLE_AW-1:0] raddr_a,
    input  logic [ucoll_pkg::TABLE_AW-1:0] raddr_b,
    output logic [ucoll_pkg::CODE_W-1:0]   rdata_a,
    output logic [ucoll_pkg::CODE_W-1:0]   rdata_b
);

    logic [ucoll_pkg::CODE_W-1:0] mem [ucoll_pkg::UPCASE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// File: sv/unicode_name_collator.sv
`timescale 1ns / 1ps
// The last compare item passes stage 1; its result then loads the output register.
// Throughput: one item per cycle while not stalled, set by the upcase table's two read ports.
// A blocked result register stalls the input only while a final position waits behind it.
// Reset clears the pipeline and per-pair state and sets the registers to defaults.
// Upcase table contents are undefined after reset until loaded; no clearing pass.
// ----------------------------------------------------------------------------
// unicode_name_collator
// Streams two UTF-16 names one position per transfer and orders or matches them.
// ----------------------------------------------------------------------------
`include "unicode_name_collator_assert.svh"

module unicode_name_collator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // char_a[15:0], char_b[31:16], has_a[32], has_b[33],
    // table_index[49:34], table_value[65:50], zero fill[71:66]
    input  logic [71:0] s_axis_tdata,
    // opcode[0]
    input  logic [0:0]  s_axis_tuser,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // result[31:0]
    output logic [31:0] m_axis_tdata
);

    localparam int CW = ucoll_pkg::CODE_W;
    localparam int RW = ucoll_pkg::RESULT_W;
    localparam int AW = ucoll_pkg::TABLE_AW;
    localparam int LW = ucoll_pkg::LEN_W;

    // Configuration registers.
    logic          cfg_mode_reg;
    logic          cfg_ignore_reg;
    logic [LW-1:0] cfg_len_reg;
    logic [RW-1:0] cfg_error_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_mode_reg   <= ucoll_pkg::MODE_COLLATE;
            cfg_ignore_reg <= 1'b0;
            cfg_len_reg    <= '0;
            cfg_error_reg  <= ucoll_pkg::ERROR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ucoll_pkg::CFG_COMPARE_MODE:  cfg_mode_reg   <= cfg_data[0];
                ucoll_pkg::CFG_IGNORE_CASE:   cfg_ignore_reg <= cfg_data[0];
                ucoll_pkg::CFG_UPCASE_LENGTH: cfg_len_reg    <= cfg_data[LW-1:0];
                ucoll_pkg::CFG_ERROR_VALUE:   cfg_error_reg  <= cfg_data[RW-1:0];
                default:                      cfg_mode_reg   <= cfg_mode_reg;
            endcase
        end
    end

    // Input field unpacking.
    logic [CW-1:0] in_char_a;
    logic [CW-1:0] in_char_b;
    logic          in_has_a;
    logic          in_has_b;
    logic [CW-1:0] in_table_index;
    logic [CW-1:0] in_table_value;
    logic          in_is_compare;

    assign in_char_a      = s_axis_tdata[15:0];
    assign in_char_b      = s_axis_tdata[31:16];
    assign in_has_a       = s_axis_tdata[32];
    assign in_has_b       = s_axis_tdata[33];
    assign in_table_index = s_axis_tdata[49:34];
    assign in_table_value = s_axis_tdata[65:50];
    assign in_is_compare  = (s_axis_tuser[0] == ucoll_pkg::OP_COMPARE);

    // Stage 1 registers: a compare item waiting on its table reads.
    logic          s1_valid_reg;
    logic [CW-1:0] s1_char_a_reg;
    logic [CW-1:0] s1_char_b_reg;
    logic          s1_has_a_reg;
    logic          s1_has_b_reg;
    logic          s1_last_reg;
    logic          s1_map_a_reg;
    logic          s1_map_b_reg;

    // Output register.
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [RW-1:0] out_data_reg;

    // Per-pair state.
    logic          decided_reg;
    logic          decided_next;
    logic [RW-1:0] held_reg;
    logic [RW-1:0] held_next;
    logic          past_nul_reg;
    logic          past_nul_next;

    logic          s1_move;
    logic          s_accept;
    logic          produce;
    logic          table_we;
    logic          map_a;
    logic          map_b;
    logic [CW-1:0] rd_a;
    logic [CW-1:0] rd_b;
    logic [CW-1:0] code_a;
    logic [CW-1:0] code_b;
    logic [RW-1:0] pair_result;

    // Stage 1 may advance unless it holds a final item and the output is blocked.
    assign s1_move  = !(s1_valid_reg && s1_last_reg && out_valid_reg && !m_axis_tready);
    assign s_axis_tready = s1_move;
    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign produce  = s1_valid_reg && s1_last_reg && s1_move;

    assign table_we = s_accept && !in_is_compare &&
                      ({1'b0, in_table_index} < ucoll_pkg::DEPTH_LIMIT);
    assign map_a = cfg_ignore_reg && ({1'b0, in_char_a} < cfg_len_reg) &&
                   ({1'b0, in_char_a} < ucoll_pkg::DEPTH_LIMIT);
    assign map_b = cfg_ignore_reg && ({1'b0, in_char_b} < cfg_len_reg) &&
                   ({1'b0, in_char_b} < ucoll_pkg::DEPTH_LIMIT);

    ucoll_table u_table (
        .clk     (clk),
        .we      (table_we),
        .waddr   (in_table_index[AW-1:0]),
        .wdata   (in_table_value),
        .re      (s_accept && in_is_compare),
        .raddr_a (in_char_a[AW-1:0]),
        .raddr_b (in_char_b[AW-1:0]),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= s_accept && in_is_compare;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_char_a_reg <= in_char_a;
            s1_char_b_reg <= in_char_b;
            s1_has_a_reg  <= in_has_a;
            s1_has_b_reg  <= in_has_b;
            s1_last_reg   <= s_axis_tlast;
            s1_map_a_reg  <= map_a;
            s1_map_b_reg  <= map_b;
        end
    end

    assign code_a = s1_map_a_reg ? rd_a : s1_char_a_reg;
    assign code_b = s1_map_b_reg ? rd_b : s1_char_b_reg;

    // Decision for the position in stage 1.
    always_comb
    begin
        decided_next  = decided_reg;
        held_next     = held_reg;
        past_nul_next = past_nul_reg;
        if (!decided_reg)
        begin
            if (cfg_mode_reg == ucoll_pkg::MODE_COLLATE)
            begin
                priority if (s1_has_a_reg && s1_has_b_reg)
                begin
                    if (ucoll_pkg::illegal_code(code_a))
                    begin
                        decided_next = 1'b1;
                        held_next    = cfg_error_reg;
                    end
                    else if (code_a < code_b)
                    begin
                        decided_next = 1'b1;
                        held_next    = ucoll_pkg::RES_LESS;
                    end
                    else if (code_a > code_b)
                    begin
                        decided_next = 1'b1;
                        held_next    = ucoll_pkg::RES_ONE;
                    end
                end
                else if (s1_has_a_reg)
                begin
                    // A surplus first-name character is checked unmapped.
                    decided_next = 1'b1;
                    held_next    = ucoll_pkg::illegal_code(s1_char_a_reg) ?
                                   cfg_error_reg : ucoll_pkg::RES_ONE;
                end
                else if (s1_has_b_reg)
                begin
                    decided_next = 1'b1;
                    held_next    = ucoll_pkg::RES_LESS;
                end
                else
                begin
                    decided_next = decided_reg;
                end
            end
            else
            begin
                priority if (s1_has_a_reg != s1_has_b_reg)
                begin
                    decided_next = 1'b1;
                    held_next    = ucoll_pkg::RES_ZERO;
                end
                else if (s1_has_a_reg && !past_nul_reg)
                begin
                    if (code_a != code_b)
                    begin
                        decided_next = 1'b1;
                        held_next    = ucoll_pkg::RES_ZERO;
                    end
                    else if (cfg_ignore_reg && (code_a == '0))
                    begin
                        past_nul_next = 1'b1;
                    end
                end
                else
                begin
                    decided_next = decided_reg;
                end
            end
        end
    end

    assign pair_result = decided_next ? held_next :
                         ((cfg_mode_reg == ucoll_pkg::MODE_COLLATE) ?
                          ucoll_pkg::RES_ZERO : ucoll_pkg::RES_ONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decided_reg  <= 1'b0;
            held_reg     <= '0;
            past_nul_reg <= 1'b0;
        end
        else if (s1_valid_reg && s1_move)
        begin
            if (s1_last_reg)
            begin
                decided_reg  <= 1'b0;
                held_reg     <= '0;
                past_nul_reg <= 1'b0;
            end
            else
            begin
                decided_reg  <= decided_next;
                held_reg     <= held_next;
                past_nul_reg <= past_nul_next;
            end
        end
    end

    always_comb
    begin
        if (produce)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (produce)
        begin
            out_data_reg <= pair_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `UCOLL_ASSERT_NEXT(a_load_no_stage1, s_accept && !in_is_compare, !s1_valid_reg,
        "load item entered the compare stage")
    `UCOLL_ASSERT_NEXT(a_pair_state_cleared, produce, !decided_reg && !past_nul_reg,
        "per-pair state not cleared after a final position")
    `UCOLL_ASSERT_NOW(a_blocked_final_holds,
        s1_valid_reg && s1_last_reg && out_valid_reg && !m_axis_tready,
        !s_axis_tready && !produce,
        "final position advanced while the result register was blocked")
    `UCOLL_ASSERT_NEXT(a_produce_sets_valid, produce, out_valid_reg,
        "finished pair did not load the result register")

endmodule

// File: test/unicode_name_collator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unicode_name_collator_tb
// Streams name pairs and upcase table loads into the collator and checks each
// verdict against a cycle-free model of the ordering and equality rules or a
// stated value. A short table of directed transfers comes first, then random
// name pairs in phases with different register settings, random gaps and output stalls.
// ----------------------------------------------------------------------------
module unicode_name_collator_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 4;
    localparam int PHASE_ITEMS = 40;

    typedef struct packed {
        logic        op;
        logic [15:0] ca;
        logic [15:0] cb;
        logic        ha;
        logic        hb;
        logic        last_pos;
        logic [15:0] tidx;
        logic [15:0] tval;
    } name_item_t;

    typedef struct {
        bit          is_cfg;
        logic [1:0]  reg_idx;
        logic [31:0] reg_val;
        name_item_t  it;
        bit          typed;
        logic [31:0] want;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = ucoll_pkg::CFG_COMPARE_MODE;
    logic [31:0] cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic [0:0]  s_axis_tuser = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;

    // Model of the block: registers, per-pair state and the upcase table.
    logic        p_mode = ucoll_pkg::MODE_COLLATE;
    logic        p_icase = 1'b0;
    logic [16:0] p_len = '0;
    logic [31:0] p_err = ucoll_pkg::ERROR_RESET;
    logic        pair_decided = 1'b0;
    logic [31:0] pair_held = '0;
    logic        pair_past_nul = 1'b0;
    logic [15:0] upcase_tbl [0:65535];
    bit          entry_loaded [0:65535];

    logic [31:0] verdict_q [$];
    plan_row_t   directed_plan [$];
    logic [31:0] got_want;
    int          mismatches = 0;
    int          items_sent = 0;
    int          cycles = 0;
    int          hold_left = 0;
    bit          squeeze_req = 1'b0;
    bit          calm = 1'b0;

    unicode_name_collator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("mismatch at %0t: %s, expected %h, got %h", $time, what, want, got);
        mismatches++;
    endtask

    function automatic bit forbidden_char(input logic [15:0] c);
        return (c < ucoll_pkg::ASCII_LIMIT) &&
               (c == ucoll_pkg::CH_QUOTE || c == ucoll_pkg::CH_STAR ||
                c == ucoll_pkg::CH_LESS || c == ucoll_pkg::CH_GREATER ||
                c == ucoll_pkg::CH_QUESTION);
    endfunction

    function automatic logic [15:0] fold_case(input logic [15:0] c);
        if (p_icase && {1'b0, c} < p_len)
            return upcase_tbl[c];
        return c;
    endfunction

    function automatic void settle(input logic [31:0] v);
        pair_decided = 1'b1;
        pair_held = v;
    endfunction

    // Applies one accepted transfer; returns 1 when it ends a name pair.
    function automatic bit judge_position(input name_item_t it, output logic [31:0] verdict);
        logic [15:0] ua;
        logic [15:0] ub;
        verdict = '0;
        if (it.op == ucoll_pkg::OP_LOAD)
        begin
            upcase_tbl[it.tidx] = it.tval;
            return 1'b0;
        end
        ua = fold_case(it.ca);
        ub = fold_case(it.cb);
        if (!pair_decided)
        begin
            if (p_mode == ucoll_pkg::MODE_COLLATE)
            begin
                if (it.ha && it.hb)
                begin
                    if (forbidden_char(ua))
                        settle(p_err);
                    else if (ua < ub)
                        settle(ucoll_pkg::RES_LESS);
                    else if (ua > ub)
                        settle(ucoll_pkg::RES_ONE);
                end
                else if (it.ha)
                    // A surplus first-name character is checked unmapped.
                    settle(forbidden_char(it.ca) ? p_err : ucoll_pkg::RES_ONE);
                else if (it.hb)
                    settle(ucoll_pkg::RES_LESS);
            end
            else
            begin
                if (it.ha != it.hb)
                    settle(ucoll_pkg::RES_ZERO);
                else if (it.ha && !pair_past_nul)
                begin
                    if (ua != ub)
                        settle(ucoll_pkg::RES_ZERO);
                    else if (p_icase && ua == 16'h0000)
                        pair_past_nul = 1'b1;
                end
            end
        end
        if (!it.last_pos)
            return 1'b0;
        verdict = pair_decided ? pair_held :
                  (p_mode == ucoll_pkg::MODE_COLLATE ? ucoll_pkg::RES_ZERO : ucoll_pkg::RES_ONE);
        pair_decided = 1'b0;
        pair_held = '0;
        pair_past_nul = 1'b0;
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [15:0] any_char();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1:
            begin
                case ($urandom_range(0, 4))
                    0: return ucoll_pkg::CH_QUOTE;
                    1: return ucoll_pkg::CH_STAR;
                    2: return ucoll_pkg::CH_LESS;
                    3: return ucoll_pkg::CH_GREATER;
                    default: return ucoll_pkg::CH_QUESTION;
                endcase
            end
            2, 3, 4, 5: return 16'h0040 + 16'($urandom_range(0, 63));
            6: return 16'($urandom_range(0, 255));
            7: return 16'hFFFF - 16'($urandom_range(0, 3));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic name_item_t random_load();
        name_item_t ld;
        ld.op = ucoll_pkg::OP_LOAD;
        ld.ca = 16'($urandom_range(0, 65535));
        ld.cb = 16'($urandom_range(0, 65535));
        ld.ha = 1'($urandom_range(0, 1));
        ld.hb = 1'($urandom_range(0, 1));
        ld.last_pos = 1'($urandom_range(0, 1));
        ld.tidx = 16'($urandom_range(0, 65535));
        ld.tval = 16'($urandom_range(0, 65535));
        return ld;
    endfunction

    function automatic plan_row_t cmp_row(input logic [15:0] ca, input logic [15:0] cb,
                                          input int ha, input int hb, input int lst,
                                          input int typed, input logic [31:0] want);
        plan_row_t r;
        r.is_cfg = 1'b0;
        r.reg_idx = ucoll_pkg::CFG_COMPARE_MODE;
        r.reg_val = '0;
        r.it = '{op: ucoll_pkg::OP_COMPARE, ca: ca, cb: cb, ha: 1'(ha), hb: 1'(hb),
                 last_pos: 1'(lst), tidx: 16'h0000, tval: 16'h0000};
        r.typed = 1'(typed);
        r.want = want;
        return r;
    endfunction

    function automatic plan_row_t load_row(input logic [15:0] idx, input logic [15:0] val,
                                           input logic lst);
        plan_row_t r;
        r = cmp_row(16'hFFFF, 16'h0000, 1, 1, 0, 0, '0);
        r.it.op = ucoll_pkg::OP_LOAD;
        r.it.last_pos = lst;
        r.it.tidx = idx;
        r.it.tval = val;
        return r;
    endfunction

    function automatic plan_row_t cfg_row(input logic [1:0] idx, input logic [31:0] val);
        plan_row_t r;
        r = cmp_row(16'h0000, 16'h0000, 0, 0, 0, 0, '0);
        r.is_cfg = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    task automatic send_item(input name_item_t it, input bit typed, input logic [31:0] want);
        int gap;
        bit ends_pair;
        logic [31:0] verdict;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'b0, it.tval, it.tidx, it.hb, it.ha, it.cb, it.ca};
        s_axis_tuser <= it.op;
        s_axis_tlast <= it.last_pos;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        ends_pair = judge_position(it, verdict);
        if (it.op == ucoll_pkg::OP_LOAD)
            entry_loaded[it.tidx] = 1'b1;
        if (ends_pair)
            verdict_q.push_back(typed ? want : verdict);
        items_sent++;
    endtask

    // Registers change only with the pipeline empty.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        s_axis_tvalid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            ucoll_pkg::CFG_COMPARE_MODE: p_mode = val[0];
            ucoll_pkg::CFG_IGNORE_CASE: p_icase = val[0];
            ucoll_pkg::CFG_UPCASE_LENGTH: p_len = val[16:0];
            default: p_err = val;
        endcase
        @(posedge clk);
    endtask

    // Loads a table entry first when a compare would read one never written.
    task automatic ensure_entry(input logic [15:0] code);
        name_item_t ld;
        if (!p_icase || {1'b0, code} >= p_len || entry_loaded[code])
            return;
        ld = random_load();
        ld.tidx = code;
        case ($urandom_range(0, 5))
            0: ld.tval = code;
            1: ld.tval = 16'h0000;
            2: ld.tval = ucoll_pkg::CH_QUESTION;
            3: ld.tval = 16'($urandom_range(0, 65535));
            default: ld.tval = code & ~16'h0020;
        endcase
        send_item(ld, 1'b0, '0);
    endtask

    task automatic send_name_pair();
        logic [15:0] na [10];
        logic [15:0] nb [10];
        int la;
        int lb;
        int n;
        int style;
        name_item_t it;
        la = $urandom_range(0, 6);
        lb = la;
        style = $urandom_range(0, 9);
        foreach (na[i])
        begin
            na[i] = any_char();
            nb[i] = na[i];
        end
        case (style)
            0, 1, 2:
                foreach (nb[i])
                    if ($urandom_range(0, 2) == 0)
                        nb[i] = nb[i] ^ 16'h0020;
            3, 4:
                if (la > 0)
                    nb[$urandom_range(0, la - 1)] = any_char();
            5, 6:
                lb = $urandom_range(0, 6);
            7, 8:
            begin
                lb = $urandom_range(0, 6);
                foreach (nb[i])
                    nb[i] = any_char();
            end
            default: ;
        endcase
        n = (la > lb) ? la : lb;
        if ($urandom_range(0, 3) == 0)
            n += $urandom_range(1, 2);
        // Broken pairs: flags in any order, with holes.
        if (style == 9)
            n = $urandom_range(1, 8);
        if (n == 0)
            n = 1;
        for (int i = 0; i < n; i++)
        begin
            it.op = ucoll_pkg::OP_COMPARE;
            if (style == 9)
            begin
                it.ha = 1'($urandom_range(0, 1));
                it.hb = 1'($urandom_range(0, 1));
            end
            else
            begin
                it.ha = (i < la);
                it.hb = (i < lb);
            end
            it.ca = it.ha ? na[i] : 16'($urandom_range(0, 65535));
            it.cb = it.hb ? nb[i] : 16'($urandom_range(0, 65535));
            it.last_pos = (i == n - 1);
            it.tidx = 16'($urandom_range(0, 65535));
            it.tval = 16'($urandom_range(0, 65535));
            if ($urandom_range(0, 19) == 0)
                send_item(random_load(), 1'b0, '0);
            ensure_entry(it.ca);
            ensure_entry(it.cb);
            send_item(it, 1'b0, '0);
        end
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (squeeze_req)
            begin
                squeeze_req = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 99) < 20)
            begin
                hold_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                         : $urandom_range(9, 39);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (verdict_q.size() == 0)
                report_mismatch("result with nothing pending", '0, m_axis_tdata);
            else
            begin
                got_want = verdict_q.pop_front();
                if (m_axis_tdata !== got_want)
                    report_mismatch("result", got_want, m_axis_tdata);
            end
        end
    end

    initial
    begin
        int start;
        int len_pick;
        logic [31:0] err_pick;

        // Defaults after reset, extremes, and positions with neither name present.
        directed_plan.push_back(cmp_row(16'h0041, 16'h0042, 1, 1, 1, 1, ucoll_pkg::RES_LESS));
        directed_plan.push_back(cmp_row(16'h0042, 16'h0041, 1, 1, 1, 1, ucoll_pkg::RES_ONE));
        directed_plan.push_back(cmp_row(ucoll_pkg::CH_QUESTION, 16'h0010, 1, 1, 1, 1,
                                        ucoll_pkg::ERROR_RESET));
        directed_plan.push_back(cmp_row(ucoll_pkg::CH_STAR, 16'h0041, 1, 0, 1, 1,
                                        ucoll_pkg::ERROR_RESET));
        directed_plan.push_back(cmp_row(16'h0041, 16'h0041, 0, 1, 1, 1, ucoll_pkg::RES_LESS));
        directed_plan.push_back(cmp_row(16'hFFFF, 16'hFFFF, 0, 0, 1, 1, ucoll_pkg::RES_ZERO));
        directed_plan.push_back(cmp_row(16'hFFFF, 16'hFFFF, 1, 1, 0, 0, '0));
        directed_plan.push_back(cmp_row(16'h0000, 16'h0000, 0, 0, 0, 0, '0));
        directed_plan.push_back(cmp_row(16'h0000, 16'hFFFF, 1, 1, 1, 1, ucoll_pkg::RES_LESS));
        // Loads never end a pair, even with tlast set.
        directed_plan.push_back(load_row(16'h0000, 16'h0000, 1'b1));
        directed_plan.push_back(load_row(16'h0041, 16'h0041, 1'b0));
        directed_plan.push_back(load_row(16'h0061, 16'h0041, 1'b1));
        directed_plan.push_back(load_row(16'h00E0, ucoll_pkg::CH_QUESTION, 1'b0));
        directed_plan.push_back(load_row(16'hFFFF, 16'hFFFF, 1'b0));
        directed_plan.push_back(cfg_row(ucoll_pkg::CFG_IGNORE_CASE, 32'd1));
        directed_plan.push_back(cfg_row(ucoll_pkg::CFG_UPCASE_LENGTH, 32'h0000_0100));
        directed_plan.push_back(cfg_row(ucoll_pkg::CFG_ERROR_VALUE, 32'h7FFF_FFFF));
        directed_plan.push_back(cmp_row(16'h0061, 16'h0041, 1, 1, 1, 1, ucoll_pkg::RES_ZERO));
        // A code that maps onto a forbidden character is an error; unmapped it is not.
        directed_plan.push_back(cmp_row(16'h00E0, 16'h0041, 1, 1, 1, 1, 32'h7FFF_FFFF));
        directed_plan.push_back(cmp_row(16'h00E0, 16'h0041, 1, 0, 1, 1, ucoll_pkg::RES_ONE));
        directed_plan.push_back(cfg_row(ucoll_pkg::CFG_COMPARE_MODE, 32'd1));
        directed_plan.push_back(cfg_row(ucoll_pkg::CFG_UPCASE_LENGTH, 32'h0001_0000));
        directed_plan.push_back(cfg_row(ucoll_pkg::CFG_ERROR_VALUE, 32'h8000_0000));
        // Characters after an equal NUL pair are not compared.
        directed_plan.push_back(cmp_row(16'h0061, 16'h0041, 1, 1, 0, 0, '0));
        directed_plan.push_back(cmp_row(16'h0000, 16'h0000, 1, 1, 0, 0, '0));
        directed_plan.push_back(cmp_row(16'hFFFF, 16'h0041, 1, 1, 1, 1, ucoll_pkg::RES_ONE));
        directed_plan.push_back(cmp_row(16'h0041, 16'h0041, 1, 0, 1, 1, ucoll_pkg::RES_ZERO));
        // Case folding turned off in the middle of a pair.
        directed_plan.push_back(cmp_row(16'h0061, 16'h0041, 1, 1, 0, 0, '0));
        directed_plan.push_back(cfg_row(ucoll_pkg::CFG_IGNORE_CASE, 32'd0));
        directed_plan.push_back(cmp_row(16'h0041, 16'h0041, 1, 1, 1, 1, ucoll_pkg::RES_ONE));
        directed_plan.push_back(cmp_row(16'h0061, 16'h0041, 1, 1, 1, 1, ucoll_pkg::RES_ZERO));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[i])
        begin
            if (directed_plan[i].is_cfg)
                write_reg(directed_plan[i].reg_idx, directed_plan[i].reg_val);
            else
                send_item(directed_plan[i].it, directed_plan[i].typed, directed_plan[i].want);
        end

        for (int phase = 0; phase < 10; phase++)
        begin
            case ($urandom_range(0, 7))
                0: len_pick = 0;
                1: len_pick = 1;
                2: len_pick = 64;
                3: len_pick = 128;
                4: len_pick = 256;
                5: len_pick = 65535;
                6: len_pick = 65536;
                default: len_pick = $urandom_range(0, 65536);
            endcase
            case ($urandom_range(0, 4))
                0: err_pick = ucoll_pkg::ERROR_RESET;
                1: err_pick = 32'h7FFF_FFFF;
                2: err_pick = 32'h8000_0000;
                3: err_pick = ucoll_pkg::RES_ZERO;
                default: err_pick = $urandom;
            endcase
            write_reg(ucoll_pkg::CFG_COMPARE_MODE, 32'($urandom_range(0, 1)));
            write_reg(ucoll_pkg::CFG_IGNORE_CASE, ($urandom_range(0, 2) != 0) ? 32'd1 : 32'd0);
            write_reg(ucoll_pkg::CFG_UPCASE_LENGTH, 32'(len_pick));
            write_reg(ucoll_pkg::CFG_ERROR_VALUE, err_pick);
            calm = (phase == 3 || phase == 7);
            // The output holds off long enough that the block backs up.
            if (phase == 2)
                squeeze_req = 1'b1;
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS)
                send_name_pair();
        end

        s_axis_tvalid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/ucoll_pkg.sv
sv/ucoll_table.sv
sv/unicode_name_collator.sv
test/unicode_name_collator_tb.sv
